>>> hdl/itdab_pkg.sv
// Shared constants, types and the symbol lookup for the radix converter.
package itdab_pkg;

  localparam int VALUE_W       = 32;
  localparam int MINW_W        = 6;
  localparam int CHAR_W        = 8;
  localparam int RADIX_W       = 5;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int NUM_CELLS     = 32;
  localparam int OUT_LIMIT     = 64;
  localparam int MAX_WIDTH_DEF = 63;
  localparam int MAX_RADIX_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
  localparam logic [CFG_W-1:0]   SYM_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0]   SYM_HIGH_RST = 64'h4645444342413938;

  localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h30;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic bit_in;
    logic en;
  } chain_feed_t;

  // Map a digit onto its symbol byte; digits without a symbol give zero.
  function automatic logic [CHAR_W-1:0] symbol_of(input logic [7:0] d,
                                                  input logic [CFG_W-1:0] lo,
                                                  input logic [CFG_W-1:0] hi);
    logic [CHAR_W-1:0] s;
    s = '0;
    if (d < 8'd8) begin
      s = lo[{d[2:0], 3'b000} +: CHAR_W];
    end else if (d < 8'd16) begin
      s = hi[{d[2:0], 3'b000} +: CHAR_W];
    end
    return s;
  endfunction

endpackage

>>> hdl/itdab_if.sv
// Valid/ready channel interfaces for the input numbers and output characters.
interface itdab_in_if import itdab_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [MINW_W-1:0]         min_width;

  modport source (output valid, output value, output min_width, input ready);
  modport sink (input valid, input value, input min_width, output ready);
endinterface

interface itdab_out_if import itdab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

>>> hdl/integer_to_digits_any_base_padded.sv
// Top level: signed integer to zero-padded characters in a configurable base.
// Sequence: the cell row converts a word once it is accepted, then leading
//   zero digits are stripped and the padding is sized, then the first
//   character registers.
// Throughput: one character per cycle while dout.ready is high; a new number
//   is accepted only once the last character of the previous one has been
//   registered.
// Reset: synchronous rst idles the sequencer, empties the output register and
//   loads radix 10 with symbols "0123456789ABCDEF".
module integer_to_digits_any_base_padded import itdab_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_RADIX = MAX_RADIX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  itdab_in_if.sink             din,
  itdab_out_if.source          dout,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int VW      = DIGIT_W + 1;

  // Cell 0 holds the least significant digit; the magnitude enters there,
  // MSB first. Each cell doubles its digit, adds the carry from below and
  // subtracts the base when it overflows, passing the carry up one cell per
  // cycle. The bit stream therefore runs skewed through the row, each cell
  // starting its work after the cell below it.
  cell_ctrl_t         cell_ctrl;
  chain_feed_t        feed [NUM_CELLS];
  logic [DIGIT_W-1:0] digs [NUM_CELLS];
  logic [VW-1:0]      base;

  itdab_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIX (MAX_RADIX)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout),
    .top_digit (digs[NUM_CELLS-1]),
    .cell_ctrl (cell_ctrl),
    .feed      (feed[0]),
    .base      (base)
  );

  // After conversion the same row shifts upward: first to drop leading zero
  // digits, then to hand out one digit per character from the top cell.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == NUM_CELLS - 1) begin : g_top
      itdab_cell #(.MAX_RADIX (MAX_RADIX)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .base     (base),
        .feed_in  (feed[k]),
        .dig_in   (digs[k-1]),
        .feed_out (),
        .dig      (digs[k])
      );
    end else if (k == 0) begin : g_bottom
      itdab_cell #(.MAX_RADIX (MAX_RADIX)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .base     (base),
        .feed_in  (feed[k]),
        .dig_in   ({DIGIT_W{1'b0}}),
        .feed_out (feed[k+1]),
        .dig      (digs[k])
      );
    end else begin : g_mid
      itdab_cell #(.MAX_RADIX (MAX_RADIX)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .base     (base),
        .feed_in  (feed[k]),
        .dig_in   (digs[k-1]),
        .feed_out (feed[k+1]),
        .dig      (digs[k])
      );
    end
  end

endmodule

>>> hdl/itdab_cell.sv
// One digit cell: doubles its digit plus a carry, reduces by the base, shifts.
module itdab_cell import itdab_pkg::*; #(
  parameter int MAX_RADIX = MAX_RADIX_DEF,
  localparam int DIGIT_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1,
  localparam int VW       = DIGIT_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [VW-1:0]      base,
  input  chain_feed_t        feed_in,
  input  logic [DIGIT_W-1:0] dig_in,
  output chain_feed_t        feed_out,
  output logic [DIGIT_W-1:0] dig
);

  logic [VW-1:0] v;
  logic [VW-1:0] reduced;
  logic          ge;

  assign v       = {dig, feed_in.bit_in};
  assign ge      = (v >= base);
  assign reduced = ge ? (v - base) : v;

  // Carry and enable move one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_out <= '0;
    end else begin
      feed_out.en     <= feed_in.en;
      feed_out.bit_in <= feed_in.en & ge;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      dig <= '0;
    end else if (ctrl.shift) begin
      dig <= dig_in;
    end else if (feed_in.en) begin
      dig <= reduced[DIGIT_W-1:0];
    end
  end

endmodule

>>> hdl/itdab_ctrl.sv
// Sequencer: config registers, magnitude feed, normalize and character output.
module itdab_ctrl import itdab_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_RADIX = MAX_RADIX_DEF,
  localparam int DIGIT_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1,
  localparam int VW       = DIGIT_W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  itdab_in_if.sink             din,
  itdab_out_if.source          dout,
  input  logic [DIGIT_W-1:0]   top_digit,
  output cell_ctrl_t           cell_ctrl,
  output chain_feed_t          feed,
  output logic [VW-1:0]        base
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_NORM  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_DIGIT = 3'd5;

  localparam logic [5:0] CONV_LAST = 6'(2 * NUM_CELLS - 2);

  logic [2:0]         state;
  logic [5:0]         cnt;
  logic [5:0]         dig_cnt;
  logic [6:0]         pad_cnt;
  logic [RADIX_W-1:0] radix;
  logic [CFG_W-1:0]   sym_lo;
  logic [CFG_W-1:0]   sym_hi;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;
  logic [VALUE_W-1:0] mag_sh;
  logic               neg;
  logic [MINW_W-1:0]  width_c;

  logic               accept;
  logic               take;
  logic               norm_shift;
  logic [6:0]         body;
  logic [6:0]         total;
  logic [6:0]         pad_next;
  logic [7:0]         base_wide;

  assign accept     = din.valid & din.ready;
  assign take       = ~out_valid | dout.ready;
  assign din.ready  = (state == S_IDLE);
  assign norm_shift = (state == S_NORM) && (top_digit == '0) && (dig_cnt != 6'd1);

  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.last      = out_last;

  assign cell_ctrl.clr   = accept;
  assign cell_ctrl.shift = norm_shift || ((state == S_DIGIT) && take);
  assign feed.en         = (state == S_CONV) && (cnt < 6'(NUM_CELLS));
  assign feed.bit_in     = mag_sh[VALUE_W-1];

  // Clamp the base to 2 .. MAX_RADIX.
  always_comb begin
    if (radix < 5'd2) begin
      base_wide = 8'd2;
    end else if (8'(radix) > 8'(MAX_RADIX)) begin
      base_wide = 8'(MAX_RADIX);
    end else begin
      base_wide = 8'(radix);
    end
  end
  assign base = base_wide[VW-1:0];

  always_comb begin
    body  = 7'(dig_cnt) + 7'(neg);
    total = (body > 7'(width_c)) ? body : 7'(width_c);
    if (total > 7'(OUT_LIMIT)) begin
      total = 7'(OUT_LIMIT);
    end
    pad_next = total - body;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      dig_cnt   <= '0;
      pad_cnt   <= '0;
      out_valid <= 1'b0;
      radix     <= RADIX_RST;
      sym_lo    <= SYM_LOW_RST;
      sym_hi    <= SYM_HIGH_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX:    radix  <= cfg_data[RADIX_W-1:0];
          REG_SYM_LOW:  sym_lo <= cfg_data;
          REG_SYM_HIGH: sym_hi <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (din.valid) begin
            state   <= S_CONV;
            cnt     <= '0;
            dig_cnt <= 6'(NUM_CELLS);
          end
        end
        S_CONV: begin
          cnt <= cnt + 6'd1;
          if (cnt == CONV_LAST) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (norm_shift) begin
            dig_cnt <= dig_cnt - 6'd1;
          end else begin
            pad_cnt <= pad_next;
            if (neg) begin
              state <= S_SIGN;
            end else if (pad_next != 7'd0) begin
              state <= S_PAD;
            end else begin
              state <= S_DIGIT;
            end
          end
        end
        S_SIGN: begin
          if (take) begin
            out_valid <= 1'b1;
            state     <= (pad_cnt != 7'd0) ? S_PAD : S_DIGIT;
          end
        end
        S_PAD: begin
          if (take) begin
            out_valid <= 1'b1;
            pad_cnt   <= pad_cnt - 7'd1;
            if (pad_cnt == 7'd1) begin
              state <= S_DIGIT;
            end
          end
        end
        S_DIGIT: begin
          if (take) begin
            out_valid <= 1'b1;
            dig_cnt   <= dig_cnt - 6'd1;
            if (dig_cnt == 6'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: sign, clamped width, magnitude feed and output word.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg    <= din.value[VALUE_W-1];
      mag_sh <= din.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(din.value))
                                     : VALUE_W'(din.value);
      if (int'(din.min_width) > MAX_WIDTH) begin
        width_c <= MINW_W'(MAX_WIDTH);
      end else begin
        width_c <= din.min_width;
      end
    end else if (state == S_CONV) begin
      mag_sh <= {mag_sh[VALUE_W-2:0], 1'b0};
    end
    if (take) begin
      case (state)
        S_SIGN: begin
          out_char <= MINUS_CHAR;
          out_last <= 1'b0;
        end
        S_PAD: begin
          out_char <= PAD_CHAR;
          out_last <= 1'b0;
        end
        S_DIGIT: begin
          out_char <= symbol_of(8'(top_digit), sym_lo, sym_hi);
          out_last <= (dig_cnt == 6'd1);
        end
        default: ;
      endcase
    end
  end

endmodule
